// ===== sv/sdc_pkg.sv =====
// shared types, constants and reply tables of the sd card spi responder
// no dependencies
`default_nettype none

package sdc_pkg;

	localparam int NUM_BLOCKS_DEF = 128;
	localparam int BLOCK_BYTES    = 512;
	localparam int FRAME_LEN      = 515;
	localparam int CMD_LEN        = 6;
	localparam int BLOCK_REPLY    = 2 + BLOCK_BYTES + 2;
	localparam int BUF_AW         = 10;

	localparam logic OP_XCHG   = 1'b0;
	localparam logic OP_SELECT = 1'b1;

	localparam logic [7:0] BYTE_IDLE   = 8'hFF;
	localparam logic [7:0] TOKEN_WRITE = 8'hFE;

	localparam logic [7:0] CMD_GO_IDLE  = 8'd0;
	localparam logic [7:0] CMD_IF_COND  = 8'd8;
	localparam logic [7:0] CMD_STATUS   = 8'd13;
	localparam logic [7:0] CMD_READ     = 8'd17;
	localparam logic [7:0] CMD_WRITE    = 8'd24;
	localparam logic [7:0] CMD_APP      = 8'd55;
	localparam logic [7:0] CMD_READ_OCR = 8'd58;
	localparam logic [7:0] ACMD_OP_COND = 8'h80 | 8'd41;

	typedef enum logic [2:0] {
		KIND_NONE,
		KIND_R1,
		KIND_R2_READY,
		KIND_R2_BUSY,
		KIND_R3,
		KIND_R7,
		KIND_BLOCK
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_MODR,
		ST_MODW,
		ST_SNAP,
		ST_COMMIT
	} state_t;

	function automatic logic [9:0] reply_len(input kind_t kind);
		logic [9:0] len;
		case (kind)
			KIND_R1:       len = 10'd1;
			KIND_R2_READY: len = 10'd2;
			KIND_R2_BUSY:  len = 10'd2;
			KIND_R3:       len = 10'd4;
			KIND_R7:       len = 10'd5;
			KIND_BLOCK:    len = 10'(BLOCK_REPLY);
			default:       len = 10'd0;
		endcase
		return len;
	endfunction

	function automatic logic [7:0] reply_byte(input kind_t kind, input logic [9:0] idx,
			input logic r1, input logic [7:0] snap);
		logic [7:0] v;
		v = 8'hFF;
		case (kind)
			KIND_R1:       v = {7'd0, r1};
			KIND_R2_READY: v = 8'h00;
			KIND_R2_BUSY:  v = idx[0] ? 8'hFF : 8'h1F;
			KIND_R3: begin
				case (idx)
					10'd0:   v = 8'hC0;
					10'd1:   v = 8'hFF;
					10'd2:   v = 8'h80;
					10'd3:   v = 8'h00;
					default: v = 8'hFF;
				endcase
			end
			KIND_R7: begin
				case (idx)
					10'd0:   v = 8'h01;
					10'd1:   v = 8'h00;
					10'd2:   v = 8'h00;
					10'd3:   v = 8'h01;
					10'd4:   v = 8'hAA;
					default: v = 8'hFF;
				endcase
			end
			KIND_BLOCK: begin
				if (idx == 10'd0) v = 8'h00;
				else if (idx == 10'd1) v = 8'hFE;
				else if (idx < 10'(2 + BLOCK_BYTES)) v = snap;
				else v = 8'h00;
			end
			default: v = 8'hFF;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// ===== sv/sdc_ram.sv =====
// simple dual port ram, one write and one registered read per cycle
// no dependencies
`default_nettype none

module sdc_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== sv/sdc_mod.sv =====
// block address reduction: 32-bit block address modulo NUM_BLOCKS by reciprocal multiply
// depends on sdc_pkg
`default_nettype none

module sdc_mod #(
	parameter int NUM_BLOCKS = sdc_pkg::NUM_BLOCKS_DEF,
	parameter int BLK_W      = 7
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [31:0]      value,
	output logic                  done,
	output logic      [BLK_W-1:0] rem
);

	// floor((2^32 - 1) / N) keeps the quotient estimate at most one below the true one
	localparam logic [31:0] RECIP = 32'(64'h0000_0000_FFFF_FFFF / 64'(NUM_BLOCKS));
	localparam logic [31:0] NB    = 32'(NUM_BLOCKS);

	logic [31:0]      val_s1, val_s2, val_s3;
	logic [31:0]      q_s2, qn_s3, r_s4;
	logic [31:0]      q_est;
	logic             v_s1, v_s2, v_s3, v_s4;
	logic             done_q;
	logic [BLK_W-1:0] rem_q;

	assign q_est = 32'(({32'd0, val_s1} * {32'd0, RECIP}) >> 32);
	assign done  = done_q;
	assign rem   = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= start;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			done_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_s1 <= value;
		end
		if (v_s1) begin
			q_s2   <= q_est;
			val_s2 <= val_s1;
		end
		if (v_s2) begin
			qn_s3  <= q_s2 * NB;
			val_s3 <= val_s2;
		end
		// remainder estimate lies below 2N, one conditional subtract finishes it
		if (v_s3) begin
			r_s4 <= val_s3 - qn_s3;
		end
		if (v_s4) begin
			rem_q <= BLK_W'((r_s4 >= NB) ? r_s4 - NB : r_s4);
		end
	end

endmodule

`default_nettype wire

// ===== sv/sd_card_spi_responder_core.sv =====
// sd card responder in spi mode: command decode, reply sequencing, block copies
// depends on sdc_pkg, sdc_ram, sdc_mod
`default_nettype none

// One request is one exchanged spi byte or one chip select change. A request
// is registered while the core is idle and executed in the exec state once
// the output is free. A block read command and a committed write block also
// run the block address reduction and then a copy between the card store and
// the block buffer (one byte a cycle through the store ports), holding
// in_stall high meanwhile. The store needs no clearing pass: reading
// a block that was never written returns undefined data.
module sd_card_spi_responder_core #(
	parameter int NUM_BLOCKS = sdc_pkg::NUM_BLOCKS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        opcode,
	input  wire logic [7:0]  byte_in,
	input  wire logic        select_level,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [7:0]  byte_out,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	localparam int BLK_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int ST_AW = BLK_W + 9;
	localparam int ST_DEPTH = NUM_BLOCKS * sdc_pkg::BLOCK_BYTES;

	sdc_pkg::state_t state_q, state_d;
	sdc_pkg::kind_t  kind_q, kind_d;

	logic        present_q, cs_q, app_q, idle_q, init_q, r1_q;
	logic [9:0]  fc_q, idx_q, cp_q;
	logic [7:0]  first_q, prev_q, b_q;
	logic [31:0] addr_q, wba_q;
	logic        op_q, sel_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic [BLK_W-1:0] blk_q;

	logic        out_free, do_exec, active, is_reply, cmd_end, long_end, commit;
	logic [7:0]  first_b, code, result;
	logic [9:0]  fc_inc, idx_inc, snap_off, stg_off, cp_m1;
	logic        r1_d, idle_d, init_d;

	logic             mod_start, mod_done;
	logic [31:0]      mod_val;
	logic [BLK_W-1:0] mod_rem;

	logic              buf_we;
	logic [9:0]        buf_waddr, buf_raddr;
	logic [7:0]        buf_wdata, buf_rdata;
	logic              st_we;
	logic [ST_AW-1:0]  st_waddr, st_raddr;
	logic [7:0]        st_rdata;

	// config port
	assign pready = 1'b1;
	assign prdata = (paddr == 3'd0) ? {31'd0, present_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= 1'b1;
		end else if (psel && penable && pwrite && paddr == 3'd0) begin
			present_q <= pwdata[0];
		end
	end

	// decode of the executing request
	assign out_free = !out_valid_q || !out_stall;
	assign do_exec  = (state_q == sdc_pkg::ST_EXEC) && out_free;
	assign active   = (op_q == sdc_pkg::OP_XCHG) && cs_q && present_q;
	assign is_reply = (fc_q == 10'd0) && (b_q == sdc_pkg::BYTE_IDLE);
	assign first_b  = (fc_q == 10'd0) ? b_q : first_q;
	assign fc_inc   = fc_q + 10'd1;
	assign idx_inc  = idx_q + 10'd1;
	assign snap_off = idx_q - 10'd2;
	assign stg_off  = fc_q - 10'd1;
	assign cp_m1    = cp_q - 10'd1;
	assign cmd_end  = (first_b[7:6] == 2'b01) && (fc_inc == 10'(sdc_pkg::CMD_LEN));
	assign long_end = !cmd_end && (fc_inc >= 10'(sdc_pkg::FRAME_LEN));
	assign commit   = long_end && (prev_q == sdc_pkg::CMD_WRITE)
		&& (first_b == sdc_pkg::TOKEN_WRITE);
	assign code     = {app_q, 1'b0, first_b[5:0]};

	always_comb begin
		result = sdc_pkg::BYTE_IDLE;
		if (active && is_reply && kind_q != sdc_pkg::KIND_NONE) begin
			result = sdc_pkg::reply_byte(kind_q, idx_q, r1_q, buf_rdata);
		end
	end

	// command effects
	always_comb begin
		kind_d = sdc_pkg::KIND_R1;
		idle_d = idle_q;
		init_d = init_q;
		case (code)
			sdc_pkg::CMD_GO_IDLE:  idle_d = 1'b1;
			sdc_pkg::CMD_IF_COND:  kind_d = sdc_pkg::KIND_R7;
			sdc_pkg::ACMD_OP_COND: begin
				idle_d = 1'b0;
				init_d = 1'b1;
			end
			sdc_pkg::CMD_STATUS:
				kind_d = init_q ? sdc_pkg::KIND_R2_READY : sdc_pkg::KIND_R2_BUSY;
			sdc_pkg::CMD_READ:     kind_d = sdc_pkg::KIND_BLOCK;
			sdc_pkg::CMD_READ_OCR: kind_d = sdc_pkg::KIND_R3;
			default:               kind_d = sdc_pkg::KIND_R1;
		endcase
		r1_d = idle_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sdc_pkg::ST_IDLE: if (in_valid) state_d = sdc_pkg::ST_EXEC;
			sdc_pkg::ST_EXEC: begin
				if (out_free) begin
					if (active && !is_reply && cmd_end && code == sdc_pkg::CMD_READ)
						state_d = sdc_pkg::ST_MODR;
					else if (active && !is_reply && commit)
						state_d = sdc_pkg::ST_MODW;
					else
						state_d = sdc_pkg::ST_IDLE;
				end
			end
			sdc_pkg::ST_MODR:   if (mod_done) state_d = sdc_pkg::ST_SNAP;
			sdc_pkg::ST_MODW:   if (mod_done) state_d = sdc_pkg::ST_COMMIT;
			sdc_pkg::ST_SNAP:   if (cp_q == 10'd512) state_d = sdc_pkg::ST_IDLE;
			sdc_pkg::ST_COMMIT: if (cp_q == 10'd512) state_d = sdc_pkg::ST_IDLE;
			default:            state_d = sdc_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_stall  = (state_q != sdc_pkg::ST_IDLE);
		mod_start = do_exec && (state_d == sdc_pkg::ST_MODR || state_d == sdc_pkg::ST_MODW);
		mod_val   = (state_d == sdc_pkg::ST_MODR) ? addr_q : wba_q;
		buf_we    = 1'b0;
		buf_waddr = {1'b0, stg_off[8:0]};
		buf_wdata = b_q;
		if (do_exec && active && !is_reply && fc_q >= 10'd1 && fc_q <= 10'd512) begin
			buf_we = 1'b1;
		end else if (state_q == sdc_pkg::ST_SNAP && cp_q != 10'd0) begin
			buf_we    = 1'b1;
			buf_waddr = {1'b1, cp_m1[8:0]};
			buf_wdata = st_rdata;
		end
		// snapshot read follows the reply index except while committing
		buf_raddr = (state_q == sdc_pkg::ST_COMMIT) ? {1'b0, cp_q[8:0]}
			: {1'b1, snap_off[8:0]};
		st_raddr  = {blk_q, cp_q[8:0]};
		st_waddr  = {blk_q, cp_m1[8:0]};
		st_we     = (state_q == sdc_pkg::ST_COMMIT) && (cp_q != 10'd0);
	end

	assign out_valid = out_valid_q;
	assign byte_out  = out_byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sdc_pkg::ST_IDLE;
			cs_q        <= 1'b0;
			fc_q        <= '0;
			wba_q       <= '0;
			prev_q      <= '0;
			app_q       <= 1'b0;
			idle_q      <= 1'b1;
			init_q      <= 1'b0;
			kind_q      <= sdc_pkg::KIND_NONE;
			idx_q       <= '0;
			r1_q        <= 1'b0;
			out_valid_q <= 1'b0;
			cp_q        <= '0;
		end else begin
			state_q <= state_d;
			if (do_exec && op_q == sdc_pkg::OP_XCHG) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (mod_done) begin
				cp_q <= '0;
			end else if (state_q == sdc_pkg::ST_SNAP || state_q == sdc_pkg::ST_COMMIT) begin
				cp_q <= cp_q + 10'd1;
			end
			if (do_exec) begin
				if (op_q == sdc_pkg::OP_SELECT) begin
					cs_q <= sel_q;
					fc_q <= '0;
				end else begin
					if (active && is_reply) begin
						if (kind_q != sdc_pkg::KIND_NONE) begin
							if (idx_inc >= sdc_pkg::reply_len(kind_q)) begin
								kind_q <= sdc_pkg::KIND_NONE;
								idx_q  <= '0;
							end else begin
								idx_q <= idx_inc;
							end
						end
					end else if (active) begin
						fc_q <= (cmd_end || long_end) ? 10'd0 : fc_inc;
						if (cmd_end) begin
							prev_q <= code;
							app_q  <= (code == sdc_pkg::CMD_APP);
							idle_q <= idle_d;
							init_q <= init_d;
							kind_q <= kind_d;
							r1_q   <= r1_d;
							idx_q  <= '0;
							if (code == sdc_pkg::CMD_WRITE) begin
								wba_q <= addr_q;
							end
						end
					end
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_q  <= opcode;
			b_q   <= byte_in;
			sel_q <= select_level;
		end
		if (do_exec && op_q == sdc_pkg::OP_XCHG) begin
			out_byte_q <= result;
		end
		if (do_exec && active && !is_reply) begin
			if (fc_q == 10'd0) begin
				first_q <= b_q;
			end
			if (fc_q >= 10'd1 && fc_q <= 10'd4) begin
				addr_q <= {addr_q[23:0], b_q};
			end
		end
		if (mod_done) begin
			blk_q <= mod_rem;
		end
	end

	sdc_mod #(
		.NUM_BLOCKS(NUM_BLOCKS),
		.BLK_W(BLK_W)
	) u_mod (
		.clk(clk),
		.arst_n(arst_n),
		.start(mod_start),
		.value(mod_val),
		.done(mod_done),
		.rem(mod_rem)
	);

	// lower half stages the write frame, upper half holds the read snapshot
	sdc_ram #(
		.DEPTH(2 * sdc_pkg::BLOCK_BYTES),
		.AW(sdc_pkg::BUF_AW)
	) u_buf (
		.clk(clk),
		.we(buf_we),
		.waddr(buf_waddr),
		.wdata(buf_wdata),
		.raddr(buf_raddr),
		.rdata(buf_rdata)
	);

	sdc_ram #(
		.DEPTH(ST_DEPTH),
		.AW(ST_AW)
	) u_store (
		.clk(clk),
		.we(st_we),
		.waddr(st_waddr),
		.wdata(buf_rdata),
		.raddr(st_raddr),
		.rdata(st_rdata)
	);

endmodule

`default_nettype wire
